>>> hdl/cvem_pkg.sv
package cvem_pkg;

    localparam int MAX_SAMPLES = 1048576;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int POS_W       = 20;

    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam int MEAN_STEPS = 64;
    localparam int REL_STEPS  = 112;
    localparam int SQRT_STEPS = 32;
    localparam int DCNT_W     = $clog2(REL_STEPS);
    localparam int SCNT_W     = $clog2(SQRT_STEPS);

    typedef struct packed {
        logic signed [31:0] ref_real;
        logic signed [31:0] ref_imag;
        logic signed [31:0] test_real;
        logic signed [31:0] test_imag;
        logic               vector_end;
    } sample_t;

    typedef struct packed {
        logic [31:0] max_amp_error;
        logic [19:0] worst_position;
        logic [31:0] max_component_error;
        logic [31:0] rms_error;
        logic [31:0] relative_l2;
        logic [43:0] max_prob_error;
        logic [62:0] total_prob_diff;
    } result_t;

    // Accumulated state of one finished vector.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [43:0]      peak_sq;
        logic [POS_W-1:0] peak_pos;
        logic [31:0]      peak_comp;
        logic [63:0]      diff_e;
        logic [63:0]      ref_e;
        logic [63:0]      test_e;
        logic [43:0]      peak_pd;
    } snap_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV_MEAN,
        ST_SQ_RMS,
        ST_DIV_REL,
        ST_SQ_REL,
        ST_SQ_AMP,
        ST_WAIT
    } back_state_t;

endpackage

>>> hdl/cvem_front.sv
module cvem_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  cvem_pkg::sample_t              sample,
    input  logic [cvem_pkg::QCNT_W-1:0]    q_count,
    output logic                           q_push,
    output cvem_pkg::snap_t                q_data
);

    // Stage 1: component differences and magnitudes.
    logic        s1_v_reg, s1_last_reg;
    logic [31:0] s1_dr_reg, s1_di_reg, s1_rr_reg, s1_ri_reg, s1_tr_reg, s1_ti_reg;
    // Stage 2: squares in Q4.40.
    logic        s2_v_reg, s2_last_reg;
    logic [43:0] s2_sdr_reg, s2_sdi_reg, s2_srr_reg, s2_sri_reg, s2_str_reg, s2_sti_reg;
    logic [31:0] s2_comp_reg;
    // Accumulated state.
    logic [cvem_pkg::CNT_W-1:0] count_reg;
    logic [43:0]                peak_sq_reg, peak_pd_reg;
    logic [cvem_pkg::POS_W-1:0] peak_pos_reg;
    logic [31:0]                peak_comp_reg;
    logic [63:0]                diff_e_reg, ref_e_reg, test_e_reg;

    logic                       accept;
    logic [cvem_pkg::QCNT_W:0]  pending;
    logic [32:0]                dr_w, di_w;
    logic [44:0]                d2_sum;
    logic [43:0]                d2, pr, pt, pd;
    logic                       take;
    cvem_pkg::snap_t            acc_next;
    logic [64:0]                sum_d, sum_r, sum_t;

    function automatic logic [31:0] mag33(input logic [32:0] x);
        logic [32:0] n;
        n = -x;
        return x[32] ? n[31:0] : x[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return mag33({x[31], x});
    endfunction

    // A vector end still in the pipeline holds a queue slot in advance.
    assign pending = {1'b0, q_count}
                   + (cvem_pkg::QCNT_W+1)'(s1_v_reg & s1_last_reg)
                   + (cvem_pkg::QCNT_W+1)'(s2_v_reg & s2_last_reg);
    assign full   = pending >= (cvem_pkg::QCNT_W+1)'(cvem_pkg::Q_DEPTH);
    assign accept = push && !full;

    assign dr_w = {sample.test_real[31], sample.test_real} - {sample.ref_real[31], sample.ref_real};
    assign di_w = {sample.test_imag[31], sample.test_imag} - {sample.ref_imag[31], sample.ref_imag};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= sample.vector_end;
        s1_dr_reg   <= mag33(dr_w);
        s1_di_reg   <= mag33(di_w);
        s1_rr_reg   <= mag32(sample.ref_real);
        s1_ri_reg   <= mag32(sample.ref_imag);
        s1_tr_reg   <= mag32(sample.test_real);
        s1_ti_reg   <= mag32(sample.test_imag);

        s2_last_reg <= s1_last_reg;
        s2_sdr_reg  <= 44'(({32'd0, s1_dr_reg} * {32'd0, s1_dr_reg}) >> 20);
        s2_sdi_reg  <= 44'(({32'd0, s1_di_reg} * {32'd0, s1_di_reg}) >> 20);
        s2_srr_reg  <= 44'(({32'd0, s1_rr_reg} * {32'd0, s1_rr_reg}) >> 20);
        s2_sri_reg  <= 44'(({32'd0, s1_ri_reg} * {32'd0, s1_ri_reg}) >> 20);
        s2_str_reg  <= 44'(({32'd0, s1_tr_reg} * {32'd0, s1_tr_reg}) >> 20);
        s2_sti_reg  <= 44'(({32'd0, s1_ti_reg} * {32'd0, s1_ti_reg}) >> 20);
        s2_comp_reg <= (s1_dr_reg > s1_di_reg) ? s1_dr_reg : s1_di_reg;
    end

    always_comb
    begin
        d2_sum = {1'b0, s2_sdr_reg} + {1'b0, s2_sdi_reg};
        d2     = d2_sum[44] ? {44{1'b1}} : d2_sum[43:0];
        pr     = s2_srr_reg + s2_sri_reg;
        pt     = s2_str_reg + s2_sti_reg;
        pd     = (pt > pr) ? (pt - pr) : (pr - pt);
        sum_d  = {1'b0, diff_e_reg} + {21'd0, d2};
        sum_r  = {1'b0, ref_e_reg} + {21'd0, pr};
        sum_t  = {1'b0, test_e_reg} + {21'd0, pt};
        take   = s2_v_reg && (count_reg < cvem_pkg::CNT_W'(cvem_pkg::MAX_SAMPLES));

        acc_next.count     = count_reg;
        acc_next.peak_sq   = peak_sq_reg;
        acc_next.peak_pos  = peak_pos_reg;
        acc_next.peak_comp = peak_comp_reg;
        acc_next.diff_e    = diff_e_reg;
        acc_next.ref_e     = ref_e_reg;
        acc_next.test_e    = test_e_reg;
        acc_next.peak_pd   = peak_pd_reg;
        if (take)
        begin
            acc_next.count = count_reg + 1'b1;
            if (d2 > peak_sq_reg)
            begin
                acc_next.peak_sq  = d2;
                acc_next.peak_pos = cvem_pkg::POS_W'(count_reg);
            end
            if (s2_comp_reg > peak_comp_reg)
            begin
                acc_next.peak_comp = s2_comp_reg;
            end
            if (pd > peak_pd_reg)
            begin
                acc_next.peak_pd = pd;
            end
            acc_next.diff_e = sum_d[64] ? {64{1'b1}} : sum_d[63:0];
            acc_next.ref_e  = sum_r[64] ? {64{1'b1}} : sum_r[63:0];
            acc_next.test_e = sum_t[64] ? {64{1'b1}} : sum_t[63:0];
        end
    end

    assign q_push = s2_v_reg && s2_last_reg;
    assign q_data = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            peak_sq_reg   <= '0;
            peak_pos_reg  <= '0;
            peak_comp_reg <= '0;
            diff_e_reg    <= '0;
            ref_e_reg     <= '0;
            test_e_reg    <= '0;
            peak_pd_reg   <= '0;
        end
        else if (q_push)
        begin
            count_reg     <= '0;
            peak_sq_reg   <= '0;
            peak_pos_reg  <= '0;
            peak_comp_reg <= '0;
            diff_e_reg    <= '0;
            ref_e_reg     <= '0;
            test_e_reg    <= '0;
            peak_pd_reg   <= '0;
        end
        else
        begin
            count_reg     <= acc_next.count;
            peak_sq_reg   <= acc_next.peak_sq;
            peak_pos_reg  <= acc_next.peak_pos;
            peak_comp_reg <= acc_next.peak_comp;
            diff_e_reg    <= acc_next.diff_e;
            ref_e_reg     <= acc_next.ref_e;
            test_e_reg    <= acc_next.test_e;
            peak_pd_reg   <= acc_next.peak_pd;
        end
    end

endmodule

>>> hdl/cvem_queue.sv
module cvem_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  cvem_pkg::snap_t              wr_data,
    input  logic                         rd_en,
    output cvem_pkg::snap_t              rd_data,
    output logic                         q_empty,
    output logic [cvem_pkg::QCNT_W-1:0]  count
);

    cvem_pkg::snap_t             mem [cvem_pkg::Q_DEPTH];
    cvem_pkg::snap_t             rd_data_reg;
    logic [cvem_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [cvem_pkg::QCNT_W-1:0] count_reg;

    // The read data is registered, so the head entry shows up in the cycle
    // after the edge at which it is popped.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_ptr_reg];
    end

    assign rd_data = rd_data_reg;
    assign q_empty = (count_reg == '0);
    assign count   = count_reg;

    // The front never pushes into a full queue; it reserves slots ahead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + cvem_pkg::QCNT_W'(wr_en) - cvem_pkg::QCNT_W'(rd_en);
        end
    end

endmodule

>>> hdl/cvem_back.sv
module cvem_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  cvem_pkg::snap_t   q_data,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output cvem_pkg::result_t result
);

    cvem_pkg::back_state_t state_reg, state_next;

    cvem_pkg::snap_t snap_reg;
    logic [31:0]     rms_reg, rel_reg, amp_reg;
    logic            out_valid_reg;
    cvem_pkg::result_t out_reg;

    // Shared restoring divider, one quotient bit per cycle.
    logic [63:0]                 div_num_reg, div_den_reg, div_rem_reg, div_q_reg;
    logic [cvem_pkg::DCNT_W-1:0] div_cnt_reg;
    logic [64:0]                 div_sh;
    logic                        div_ge;
    logic [63:0]                 div_rem_n, div_q_n;

    // Shared integer square root, one result bit per cycle.
    logic [63:0]                 sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [cvem_pkg::SCNT_W-1:0] sq_cnt_reg;
    logic [63:0]                 sq_t, sq_v_n, sq_res_n;
    logic                        sq_ge;

    logic        div_done, sq_done, out_load;
    logic [63:0] mean_clamp;
    logic        rel_sat;
    logic [63:0] total_w;
    logic [31:0] rel_final, rms_final;

    always_comb
    begin
        div_sh    = {div_rem_reg, div_num_reg[63]};
        div_ge    = div_sh[64] || (div_sh[63:0] >= div_den_reg);
        div_rem_n = div_ge ? (div_sh[63:0] - div_den_reg) : div_sh[63:0];
        div_q_n   = {div_q_reg[62:0], div_ge};

        sq_t     = sq_res_reg + sq_bit_reg;
        sq_ge    = sq_v_reg >= sq_t;
        sq_v_n   = sq_ge ? (sq_v_reg - sq_t) : sq_v_reg;
        sq_res_n = sq_ge ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);

        mean_clamp = (div_q_n > 64'hFFF_FFFF_FFFF) ? 64'hFFF_FFFF_FFFF : div_q_n;
    end

    assign div_done = (div_cnt_reg == '0);
    assign sq_done  = (sq_cnt_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cvem_pkg::ST_IDLE:     if (!q_empty) state_next = cvem_pkg::ST_LOAD;
            cvem_pkg::ST_LOAD:     state_next = cvem_pkg::ST_DIV_MEAN;
            cvem_pkg::ST_DIV_MEAN: if (div_done) state_next = cvem_pkg::ST_SQ_RMS;
            cvem_pkg::ST_SQ_RMS:   if (sq_done)  state_next = cvem_pkg::ST_DIV_REL;
            cvem_pkg::ST_DIV_REL:  if (div_done) state_next = cvem_pkg::ST_SQ_REL;
            cvem_pkg::ST_SQ_REL:   if (sq_done)  state_next = cvem_pkg::ST_SQ_AMP;
            cvem_pkg::ST_SQ_AMP:   if (sq_done)  state_next = cvem_pkg::ST_WAIT;
            cvem_pkg::ST_WAIT:     if (out_load) state_next = cvem_pkg::ST_IDLE;
            default:               state_next = cvem_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            cvem_pkg::ST_IDLE: q_pop    = !q_empty;
            cvem_pkg::ST_WAIT: out_load = !out_valid_reg || pop;
            default:
            begin
                q_pop    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cvem_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            cvem_pkg::ST_LOAD:
            begin
                snap_reg    <= q_data;
                div_num_reg <= q_data.diff_e;
                div_den_reg <= 64'(q_data.count);
                div_rem_reg <= '0;
                div_q_reg   <= '0;
                div_cnt_reg <= cvem_pkg::DCNT_W'(cvem_pkg::MEAN_STEPS - 1);
            end
            cvem_pkg::ST_DIV_MEAN:
            begin
                div_num_reg <= div_num_reg << 1;
                div_rem_reg <= div_rem_n;
                div_q_reg   <= div_q_n;
                div_cnt_reg <= div_cnt_reg - 1'b1;
                sq_v_reg    <= mean_clamp << 20;
                sq_res_reg  <= '0;
                sq_bit_reg  <= 64'd1 << 62;
                sq_cnt_reg  <= cvem_pkg::SCNT_W'(cvem_pkg::SQRT_STEPS - 1);
            end
            cvem_pkg::ST_SQ_RMS:
            begin
                sq_v_reg    <= sq_v_n;
                sq_res_reg  <= sq_res_n;
                sq_bit_reg  <= sq_bit_reg >> 2;
                sq_cnt_reg  <= sq_cnt_reg - 1'b1;
                rms_reg     <= sq_res_n[31:0];
                div_num_reg <= snap_reg.diff_e;
                div_den_reg <= snap_reg.ref_e;
                div_rem_reg <= '0;
                div_q_reg   <= '0;
                div_cnt_reg <= cvem_pkg::DCNT_W'(cvem_pkg::REL_STEPS - 1);
            end
            cvem_pkg::ST_DIV_REL:
            begin
                div_num_reg <= div_num_reg << 1;
                div_rem_reg <= div_rem_n;
                div_q_reg   <= div_q_n;
                div_cnt_reg <= div_cnt_reg - 1'b1;
                sq_v_reg    <= div_q_n;
                sq_res_reg  <= '0;
                sq_bit_reg  <= 64'd1 << 62;
                sq_cnt_reg  <= cvem_pkg::SCNT_W'(cvem_pkg::SQRT_STEPS - 1);
            end
            cvem_pkg::ST_SQ_REL:
            begin
                if (sq_done)
                begin
                    rel_reg    <= sq_res_n[31:0];
                    sq_v_reg   <= {snap_reg.peak_sq, 20'd0};
                    sq_res_reg <= '0;
                    sq_bit_reg <= 64'd1 << 62;
                    sq_cnt_reg <= cvem_pkg::SCNT_W'(cvem_pkg::SQRT_STEPS - 1);
                end
                else
                begin
                    sq_v_reg   <= sq_v_n;
                    sq_res_reg <= sq_res_n;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg - 1'b1;
                end
            end
            cvem_pkg::ST_SQ_AMP:
            begin
                sq_v_reg   <= sq_v_n;
                sq_res_reg <= sq_res_n;
                sq_bit_reg <= sq_bit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg - 1'b1;
                amp_reg    <= sq_res_n[31:0];
            end
            default:
            begin
                snap_reg <= snap_reg;
            end
        endcase
    end

    // Final selection for the special cases.
    always_comb
    begin
        rel_sat   = (snap_reg.ref_e[63:48] == '0) &&
                    (snap_reg.diff_e >= {snap_reg.ref_e[47:0], 16'd0});
        rel_final = (snap_reg.ref_e == '0) ? 32'd0 :
                    (rel_sat ? 32'hFFFF_FFFF : rel_reg);
        rms_final = (snap_reg.count == '0) ? 32'd0 : rms_reg;
        total_w   = (snap_reg.test_e > snap_reg.ref_e) ?
                    (snap_reg.test_e - snap_reg.ref_e) : (snap_reg.ref_e - snap_reg.test_e);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.max_amp_error       <= amp_reg;
            out_reg.worst_position      <= snap_reg.peak_pos;
            out_reg.max_component_error <= snap_reg.peak_comp;
            out_reg.rms_error           <= rms_final;
            out_reg.relative_l2         <= rel_final;
            out_reg.max_prob_error      <= snap_reg.peak_pd;
            out_reg.total_prob_diff     <= total_w[63] ? {63{1'b1}} : total_w[62:0];
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

>>> hdl/complex_vector_error_metrics_unit.sv
// Channel   Handshake            Payload               Transaction
// input     push / full          sample (sample_t)     one reference and test complex sample
// result    empty / pop          result (result_t)     metrics of one finished vector
//
// Samples are taken at one per cycle while full is low; the front pipeline is three
// stages deep and folds each sample into the running sums and maxima.
// Each vector end is finished by the back unit with a shared restoring divider
// (64 steps for the mean, 112 for the relative ratio) and a shared square root unit
// (32 steps, used three times), one step per cycle. A four-entry queue holds finished
// vectors, so full rises when four vector ends, queued or still in the front pipeline,
// wait for the back unit. Reset clears the control state and accumulators at once.
module complex_vector_error_metrics_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  cvem_pkg::sample_t sample,
    output logic              empty,
    input  logic              pop,
    output cvem_pkg::result_t result
);

    logic                        q_push, q_pop, q_empty;
    cvem_pkg::snap_t             q_wr_data, q_rd_data;
    logic [cvem_pkg::QCNT_W-1:0] q_count;

    // The front accumulates each vector and hands its totals to the queue.
    cvem_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .sample  (sample),
        .q_count (q_count),
        .q_push  (q_push),
        .q_data  (q_wr_data)
    );

    cvem_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_empty (q_empty),
        .count   (q_count)
    );

    // The back unit runs the divisions and square roots, one vector at a time.
    cvem_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

>>> tb/metrics_scoreboard.sv
`timescale 1ns / 1ps

// Running model of the error metrics unit plus the list of metrics it still owes.
class metrics_scoreboard;

    localparam logic [63:0] MASK44 = (64'd1 << 44) - 64'd1;
    localparam logic [63:0] MAX63  = (64'd1 << 63) - 64'd1;

    cvem_pkg::result_t pending[$];
    int                errors;

    logic [31:0] n_samples;
    logic [63:0] top_dsq;
    logic [19:0] top_pos;
    logic [63:0] top_comp;
    logic [63:0] sum_diff;
    logic [63:0] sum_ref;
    logic [63:0] sum_test;
    logic [63:0] top_pdiff;

    function new();
        errors = 0;
        clear_vector();
    endfunction

    function void clear_vector();
        n_samples = 0;
        top_dsq   = 0;
        top_pos   = 0;
        top_comp  = 0;
        sum_diff  = 0;
        sum_ref   = 0;
        sum_test  = 0;
        top_pdiff = 0;
    endfunction

    // Magnitude of a Q2.30 value squared into Q4.40, truncated.
    function logic [63:0] square_q40(logic [63:0] m);
        return (m * m) >> 20;
    endfunction

    function logic [63:0] abs_diff(longint a, longint b);
        longint d;
        d = a - b;
        return (d < 0) ? -d : d;
    endfunction

    function logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = a + b;
        return s[64] ? '1 : s[63:0];
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Folds one accepted sample into the running metrics; a vector end queues a result.
    function void note_sample(cvem_pkg::sample_t s);
        logic [63:0]       dr, di, dsq, pr, pt, comp, pd;
        logic [63:0]       mean, rms, rel, total, amp;
        logic [111:0]      quot;
        cvem_pkg::result_t r;
        if (n_samples < cvem_pkg::MAX_SAMPLES)
        begin
            dr   = abs_diff(s.test_real, s.ref_real);
            di   = abs_diff(s.test_imag, s.ref_imag);
            dsq  = square_q40(dr) + square_q40(di);
            pr   = square_q40(abs_diff(s.ref_real, 0)) + square_q40(abs_diff(s.ref_imag, 0));
            pt   = square_q40(abs_diff(s.test_real, 0)) + square_q40(abs_diff(s.test_imag, 0));
            comp = (dr > di) ? dr : di;
            pd   = (pt > pr) ? pt - pr : pr - pt;
            if (dsq > MASK44)
                dsq = MASK44;
            // Only a strictly larger difference moves the worst position.
            if (dsq > top_dsq)
            begin
                top_dsq = dsq;
                top_pos = n_samples[19:0];
            end
            if (comp > top_comp)
                top_comp = comp;
            if (pd > top_pdiff)
                top_pdiff = pd & MASK44;
            sum_diff  = add_clamped(sum_diff, dsq);
            sum_ref   = add_clamped(sum_ref, pr);
            sum_test  = add_clamped(sum_test, pt);
            n_samples = n_samples + 1;
        end
        if (!s.vector_end)
            return;
        rms = 0;
        rel = 0;
        if (n_samples != 0)
        begin
            mean = sum_diff / n_samples;
            if (mean > MASK44)
                mean = MASK44;
            rms = floor_sqrt(mean << 20);
        end
        if (sum_ref != 0)
        begin
            if (sum_ref[63:48] == 0 && sum_diff >= (sum_ref << 16))
                rel = 64'hFFFF_FFFF;
            else
            begin
                quot = {sum_diff, 48'd0} / {48'd0, sum_ref};
                rel  = floor_sqrt(quot[63:0]);
                if (rel > 64'hFFFF_FFFF)
                    rel = 64'hFFFF_FFFF;
            end
        end
        total = (sum_test > sum_ref) ? sum_test - sum_ref : sum_ref - sum_test;
        if (total > MAX63)
            total = MAX63;
        amp = floor_sqrt(top_dsq << 20);
        r.max_amp_error       = amp[31:0];
        r.worst_position      = top_pos;
        r.max_component_error = top_comp[31:0];
        r.rms_error           = rms[31:0];
        r.relative_l2         = rel[31:0];
        r.max_prob_error      = top_pdiff[43:0];
        r.total_prob_diff     = total[62:0];
        pending = {pending, r};
        clear_vector();
    endfunction

    function void report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            if (errors <= 10)
                $display("Mismatch in %s: expected %h, got %h", name, exp_v, act_v);
        end
    endfunction

    function void check_result(cvem_pkg::result_t got);
        cvem_pkg::result_t want;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("Unexpected result transaction: %h", got);
            return;
        end
        want = pending.pop_front();
        report_field("max_amp_error", want.max_amp_error, got.max_amp_error);
        report_field("worst_position", want.worst_position, got.worst_position);
        report_field("max_component_error", want.max_component_error,
                     got.max_component_error);
        report_field("rms_error", want.rms_error, got.rms_error);
        report_field("relative_l2", want.relative_l2, got.relative_l2);
        report_field("max_prob_error", want.max_prob_error, got.max_prob_error);
        report_field("total_prob_diff", want.total_prob_diff, got.total_prob_diff);
    endfunction

endclass

>>> tb/tb_complex_vector_error_metrics_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the complex vector error metrics unit. Samples are
// pushed through the input queue interface while results are popped at random,
// and each result transaction is compared with the scoreboard's prediction.
module tb_complex_vector_error_metrics_unit;

    localparam int IDLE_LIMIT    = 20000;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int DRAIN_CYCLES  = 400;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    cvem_pkg::sample_t sample;
    logic              empty;
    logic              pop;
    cvem_pkg::result_t result;

    metrics_scoreboard sb;

    // When set, neither side inserts gaps, so back-to-back transactions occur.
    bit no_gaps;
    int pop_stall;
    int idle_cycles;

    complex_vector_error_metrics_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .sample (sample),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly no gap, often a short one, occasionally a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Presents one sample and holds it until the block takes it. With a zero
    // gap push simply stays high into the next call.
    task automatic send_sample(cvem_pkg::sample_t s);
        int gap;
        push   <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_sample(s);
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_values(logic [31:0] rr, logic [31:0] ri, logic [31:0] tr,
                               logic [31:0] ti, logic last);
        cvem_pkg::sample_t s;
        s.ref_real   = rr;
        s.ref_imag   = ri;
        s.test_real  = tr;
        s.test_imag  = ti;
        s.vector_end = last;
        send_sample(s);
    endtask

    // Random sample content: fully random words, a test close to the reference,
    // or values at the edges of the Q2.30 range.
    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    task automatic send_random(logic last);
        logic [31:0] rr, ri, tr, ti;
        int          mode;
        mode = $urandom_range(0, 9);
        rr = $urandom;
        ri = $urandom;
        if (mode < 4)
        begin
            tr = $urandom;
            ti = $urandom;
        end
        else if (mode < 8)
        begin
            // Small errors keep the relative error in its normal range.
            tr = rr + $signed($urandom_range(0, 2000)) - 1000;
            ti = ri + $signed($urandom_range(0, 2000)) - 1000;
        end
        else
        begin
            rr = edge_word();
            ri = edge_word();
            tr = edge_word();
            ti = edge_word();
        end
        send_values(rr, ri, tr, ti, last);
    endtask

    // Result side: pop high most of the time, with random stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop       <= 1'b0;
            pop_stall <= 0;
        end
        else if (pop_stall > 0 && !no_gaps)
        begin
            pop       <= 1'b0;
            pop_stall <= pop_stall - 1;
        end
        else
        begin
            pop <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                pop_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 4);
            else
                pop_stall <= 0;
        end
    end

    // Results are sampled at the edge, before the block updates its outputs.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(result);
    end

    // Watchdog: ends the run if no transaction moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int len;
        int sent;
        sb          = new();
        no_gaps     = 1'b0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        push        = 1'b0;
        sample      = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An all-zero vector has zero reference energy.
        send_values(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        // Opposite extremes: the squared difference saturates at 44 bits.
        send_values(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_values(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        // Reference of zero with a real error keeps relative_l2 at zero.
        send_values(32'h0, 32'h0, 32'h4000_0000, 32'hC000_0000, 1'b0);
        send_values(32'h0, 32'h0, 32'h0000_0001, 32'h0, 1'b1);
        // A tiny reference against a large error drives relative_l2 into saturation.
        send_values(32'h0000_1000, 32'h0, 32'h4000_0000, 32'h0, 1'b1);
        // Equal peaks: the first index must be kept, here index 1.
        send_values(32'h100, 32'h200, 32'h100, 32'h200, 1'b0);
        send_values(32'h1000_0000, 32'h0, 32'h2000_0000, 32'h0, 1'b0);
        send_values(32'h3000_0000, 32'h0, 32'h4000_0000, 32'h0, 1'b0);
        send_values(32'hF000_0000, 32'h1, 32'hE000_0000, 32'h1, 1'b1);
        // Test energy above, then below, the reference energy.
        send_values(32'h0800_0000, 32'hF800_0000, 32'h7000_0000, 32'h9000_0000, 1'b0);
        send_values(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1);
        // Several vector ends in a row fill the finished-vector queue.
        no_gaps = 1'b1;
        repeat (6) send_values(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 32'h8765_4321, 1'b1);
        no_gaps = 1'b0;

        // Hold off until every owed result has been popped.
        push <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);

        // Random vectors, mostly short, a few longer, some with no gaps at all.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            len     = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 12);
            no_gaps = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < len; i++)
                send_random(i == len - 1);
            sent += len;
            if (sent > RANDOM_ITEMS / 2 && sent - len <= RANDOM_ITEMS / 2)
            begin
                push <= 1'b0;
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
        end
        no_gaps = 1'b0;

        // A short closing vector.
        send_random(1'b0);
        send_random(1'b1);

        push <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
